// ===== rtl/core/tdp_pkg.sv =====
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared widths, constants and controller/datapath interface types for the
// trial division prime test.
// ----------------------------------------------------------------------------
`default_nettype none

package tdp_pkg;

  localparam int NUM_WIDTH   = 32;
  localparam int IN_TDATA_W  = ((NUM_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;
  localparam int CNT_W       = $clog2(NUM_WIDTH);

  localparam logic [NUM_WIDTH-1:0] DIV_FIRST = NUM_WIDTH'(3);
  localparam logic [NUM_WIDTH-1:0] DIV_INCR  = NUM_WIDTH'(2);
  localparam logic [NUM_WIDTH-1:0] SMALLEST_PRIME = NUM_WIDTH'(2);

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic next_div;
  } tdp_cmd_t;

  typedef struct packed {
    logic lt_two;
    logic is_two;
    logic is_even;
    logic div_last;
    logic bound_fail;
    logic rem_zero;
  } tdp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/tdp_datapath.sv =====
// ----------------------------------------------------------------------------
// tdp_datapath
// Candidate and divisor registers plus a one-bit-per-cycle restoring
// divider giving quotient and remainder of candidate by divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_datapath (
  input  wire                                clk_i,
  input  wire  logic [tdp_pkg::NUM_WIDTH-1:0] cand_i,
  input  wire  tdp_pkg::tdp_cmd_t            cmd_i,
  output tdp_pkg::tdp_status_t               status_o
);

  import tdp_pkg::*;

  logic [NUM_WIDTH-1:0] n_q, d_q, rem_q, quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [NUM_WIDTH:0]   shifted, diff;

  assign shifted = {rem_q, quo_q[NUM_WIDTH-1]};
  assign diff    = shifted - {1'b0, d_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= cand_i;
      d_q <= DIV_FIRST;
    end else if (cmd_i.next_div) begin
      d_q <= d_q + DIV_INCR;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= n_q;
      cnt_q <= CNT_W'(NUM_WIDTH - 1);
    end else if (cmd_i.div_step) begin
      if (!diff[NUM_WIDTH]) begin
        rem_q <= diff[NUM_WIDTH-1:0];
      end else begin
        rem_q <= shifted[NUM_WIDTH-1:0];
      end
      quo_q <= {quo_q[NUM_WIDTH-2:0], ~diff[NUM_WIDTH]};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign status_o.lt_two     = (n_q < SMALLEST_PRIME);
  assign status_o.is_two     = (n_q == SMALLEST_PRIME);
  assign status_o.is_even    = ~n_q[0];
  assign status_o.div_last   = (cnt_q == '0);
  assign status_o.bound_fail = (d_q > quo_q);
  assign status_o.rem_zero   = (rem_q == '0);

endmodule

`default_nettype wire

// ===== rtl/core/tdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdp_ctrl
// Sequencer for the prime test: screens trivial cases, runs one division
// per trial divisor, and holds the result word for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic                  out_prime_o,
  input  wire  tdp_pkg::tdp_status_t status_i,
  output tdp_pkg::tdp_cmd_t     cmd_o
);

  import tdp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIV,
    ST_EVAL,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   res_q;
  logic   slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign slot_free  = !out_valid_o || out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = in_valid_i && in_ready_o;
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.div_start = ((state_q == ST_CLASSIFY) && !status_i.lt_two && !status_i.is_even) ||
                      ((state_q == ST_EVAL) && !status_i.bound_fail && !status_i.rem_zero);
    cmd_o.next_div  = (state_q == ST_EVAL) && !status_i.bound_fail && !status_i.rem_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_q       <= 1'b0;
      out_valid_o <= 1'b0;
      out_prime_o <= 1'b0;
    end else begin
      if ((state_q == ST_FINISH) && slot_free) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CLASSIFY;
          end
        end
        ST_CLASSIFY: begin
          if (status_i.lt_two || status_i.is_even) begin
            res_q   <= status_i.is_two;
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (status_i.div_last) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (status_i.bound_fail) begin
            res_q   <= 1'b1;
            state_q <= ST_FINISH;
          end else if (status_i.rem_zero) begin
            res_q   <= 1'b0;
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            out_prime_o <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/trial_division_prime_test.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test of one unsigned number per word by odd trial divisors.
//
//   channel  | dir | tdata                         | tuser/tlast
//   s_axis   | in  | [NUM_WIDTH-1:0] candidate     | none
//   m_axis   | out | [0] is_prime, rest zero       | none
//
// Zero, one and even numbers are settled without a division, then wait for the output handshake.
// Each trial divisor runs one full division in the one-bit-per-cycle
// restoring divider; an odd candidate n takes about (sqrt(n)/2) trials.
// One word is in work at a time; the result register lets the next word in
// while a result waits. Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire  logic [tdp_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,  // candidate
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  output logic [tdp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o   // is_prime
);

  import tdp_pkg::*;

  tdp_cmd_t    cmd;
  tdp_status_t status;
  logic        prime;

  tdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_prime_o (prime),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tdp_datapath u_dp (
    .clk_i    (clk_i),
    .cand_i   (s_axis_tdata_i[NUM_WIDTH-1:0]),
    .cmd_i    (cmd),
    .status_o (status)
  );

  assign m_axis_tdata_o = {{(OUT_TDATA_W-1){1'b0}}, prime};

endmodule

`default_nettype wire

// ===== rtl/core/tdp_checker.sv =====
// ----------------------------------------------------------------------------
// tdp_checker
// Port-level checks for the prime test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_checker (
  input wire                                   clk_i,
  input wire                                   rst_ni,
  input wire                                   s_axis_tvalid_i,
  input wire                                   s_axis_tready_o,
  input wire logic [tdp_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input wire                                   m_axis_tvalid_o,
  input wire                                   m_axis_tready_i,
  input wire logic [tdp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  import tdp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second word taken while one is in work");

  a_zero_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o &&
    (s_axis_tdata_i[NUM_WIDTH-1:0] == '0)
    |-> ##3 (m_axis_tvalid_o && (m_axis_tdata_o == '0)))
    else $error("zero not reported as composite in time");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// ===== tb/prime_result_monitor.sv =====
// ----------------------------------------------------------------------------
// prime_result_monitor
// Watches both stream channels of the trial division prime test. Every
// accepted candidate word is judged on its own by odd trial division, and
// each result word is compared in order against the oldest pending verdict.
// ----------------------------------------------------------------------------
module prime_result_monitor (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_tvalid_i,
  input  wire                             s_tready_i,
  input  wire [tdp_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  input  wire                             m_tvalid_i,
  input  wire                             m_tready_i,
  input  wire [tdp_pkg::OUT_TDATA_W-1:0]  m_tdata_i,
  output int                              errors_o,
  output int                              pending_o,
  output int                              primes_o
);

  import tdp_pkg::*;

  typedef struct {
    logic [NUM_WIDTH-1:0] candidate;
    logic                 is_prime;
  } verdict_t;

  verdict_t verdict_q[$];

  function automatic logic is_prime_by_trial(logic [NUM_WIDTH-1:0] cand);
    longint unsigned n;
    longint unsigned d;
    n = 64'(cand);
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    // d <= n / d keeps the square bound free of overflow
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t v;
    if (!rst_ni) begin
      verdict_q.delete();
      pending_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        v.candidate = s_tdata_i[NUM_WIDTH-1:0];
        v.is_prime  = is_prime_by_trial(v.candidate);
        verdict_q   = {verdict_q, v};
      end
      if (m_tvalid_i && m_tready_i) begin
        if (verdict_q.size() == 0) begin
          $error("result word 0x%0h with no candidate pending", m_tdata_i);
          errors_o <= errors_o + 1;
        end else begin
          v = verdict_q.pop_front();
          if (m_tdata_i[0] !== v.is_prime) begin
            $error("is_prime mismatch for %0d: expected %0d, got %b",
                   v.candidate, v.is_prime, m_tdata_i[0]);
            errors_o <= errors_o + 1;
          end else if (m_tdata_i[OUT_TDATA_W-1:1] !== '0) begin
            $error("tdata padding mismatch for %0d: expected 0, got 0x%0h",
                   v.candidate, m_tdata_i[OUT_TDATA_W-1:1]);
            errors_o <= errors_o + 1;
          end
          if (v.is_prime) primes_o <= primes_o + 1;
        end
      end
      pending_o <= verdict_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of trial_division_prime_test: a directed set of edge
// candidates (zero, one, two, evens, squares of primes, the largest 32-bit
// prime) followed by random candidates, mostly small to bound run time,
// with full-width values that carry a small factor. Bursty sender, stalling
// receiver; checking is done in prime_result_monitor.
// ----------------------------------------------------------------------------
module testbench;
  import tdp_pkg::*;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  localparam int N_DIRECTED = 20;
  localparam int N_RANDOM   = 80;

  localparam logic [31:0] EDGE_CANDIDATES [N_DIRECTED] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd91,
    32'd97, 32'd63001, 32'd64507, 32'd65521, 32'd65536, 32'd1052651,
    32'd2147483648, 32'd4294967294, 32'd4294967295, 32'd4294967291
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    word_taken = 1'b0;

  int       errors;
  int       pending;
  int       primes;
  int       burst_left = 0;
  int       sent = 0;
  int       mode_cycles = 0;
  rx_mode_e rx_mode = RX_ALWAYS;

  always #1 clk_i = ~clk_i;

  trial_division_prime_test dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  prime_result_monitor result_monitor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .errors_o   (errors),
    .pending_o  (pending),
    .primes_o   (primes)
  );

  always @(posedge clk_i) word_taken <= s_axis_tvalid && s_axis_tready;

  // receiver backpressure: mode rerolled when its random run length runs out
  always @(negedge clk_i) begin
    if (mode_cycles == 0) begin
      mode_cycles <= $urandom_range(16, 96);
      rx_mode     <= rx_mode_e'($urandom_range(0, 3));
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    case (rx_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default:   m_axis_tready <= ~m_axis_tready;
    endcase
  end

  function automatic logic [NUM_WIDTH-1:0] random_candidate();
    int unsigned pick;
    int unsigned r;
    pick = $urandom_range(0, 99);
    r    = $urandom;
    if (pick < 40) return NUM_WIDTH'($urandom_range(0, 4095));
    if (pick < 65) return NUM_WIDTH'($urandom_range(0, 65535));
    if (pick < 75) return NUM_WIDTH'($urandom_range(0, 1 << 20));
    // full width only with a cheap factor, so the trial loop stays short
    if (pick < 90) return NUM_WIDTH'(r - r % 3);
    return NUM_WIDTH'(r & ~32'd1);
  endfunction

  task automatic send_candidate(logic [NUM_WIDTH-1:0] cand);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(cand);
    do @(negedge clk_i); while (!word_taken);
    sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (EDGE_CANDIDATES[i]) send_candidate(EDGE_CANDIDATES[i]);
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      send_candidate(random_candidate());
      if (i == N_RANDOM / 2) drain_results();
    end
    drain_results();
    repeat (20) @(negedge clk_i);

    $display("Tested %0d candidates (%0d edge cases incl. the largest 32-bit prime), %0d prime.",
             sent, N_DIRECTED, primes);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== trial_division_prime_test.f =====
rtl/core/tdp_pkg.sv
rtl/core/tdp_datapath.sv
rtl/core/tdp_ctrl.sv
rtl/core/trial_division_prime_test.sv
rtl/core/tdp_checker.sv
tb/prime_result_monitor.sv
tb/testbench.sv
